/* hw/rtl/mtwg_pkg.sv */
// Shared constants and word functions for the MT19937 word generator.
// Used by mt19937_word_generator_core; no dependencies.
package mtwg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned KEY_DEPTH_DEF = 64;
  localparam int unsigned STATE_AW     = $clog2(STATE_WORDS);

  localparam logic [STATE_AW-1:0] LAST_IDX  = STATE_AW'(STATE_WORDS - 1);
  localparam logic [STATE_AW-1:0] WRAP_IDX  = STATE_AW'(STATE_WORDS);
  localparam logic [STATE_AW-1:0] FAR_SPLIT = STATE_AW'(STATE_WORDS - TWIST_OFFSET);
  localparam logic [STATE_AW-1:0] FAR_ADD   = STATE_AW'(TWIST_OFFSET);

  localparam logic [31:0] SEED_MULT = 32'd1812433253;
  localparam logic [31:0] KEY_MULT1 = 32'd1664525;
  localparam logic [31:0] KEY_MULT2 = 32'd1566083941;
  localparam logic [31:0] INIT_SEED = 32'd19650218;
  localparam logic [31:0] TOP_BIT   = 32'h8000_0000;
  localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

  localparam logic [1:0] KIND_SEED = 2'd0;
  localparam logic [1:0] KIND_DRAW = 2'd1;
  localparam logic [1:0] KIND_KEY  = 2'd2;

  function automatic logic [31:0] mix_word(input logic [31:0] p);
    return p ^ (p >> 30);
  endfunction

  function automatic logic [31:0] twist_word(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] far);
    logic [31:0] y;
    y = (a & TOP_BIT) | (b & ~TOP_BIT);
    return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
  endfunction

  function automatic logic [31:0] temper_word(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    return y ^ (y >> 18);
  endfunction

endpackage

/* hw/rtl/mtwg_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module mtwg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mt19937_word_generator_core.sv */
// MT19937 word generator top level: sequencer around the state and key RAMs.
// Depends on mtwg_pkg and mtwg_ram.
//
// Usage: requests enter on in_valid_i/in_ready_o with kind_i, value_i and
// last_key_i. kind 0 seeds with value_i, kind 1 draws one tempered word,
// kind 2 appends value_i to the key buffer; a key word with last_key_i set
// runs the array initialization over the buffered key. Kind 3 is a no-op.
// Results leave on out_valid_o/out_ready_i with random_word_o, one per draw.
// Steps: a draw runs S_D1..S_D4 after acceptance: three reads of
// the single-port state RAM (current word, issued in the accepting cycle,
// then next and far word), one write-back of the twisted word, one output
// load. A seed writes word 0, then S_SEED_MUL (32x32 multiplier) and
// S_SEED_WR per further word; a final key word seeds with 19650218, then
// runs both key passes and S_K_FIN. Other key words and no-ops stay idle.
// in_ready_o is high only while the sequencer is idle.
// After reset the block seeds itself with 19650218 and takes
// no request meanwhile. A stalled receiver holds the result register; the
// next request is still accepted, and a following draw waits for the slot.
module mt19937_word_generator_core #(
  parameter int unsigned KEY_DEPTH = mtwg_pkg::KEY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] value_i,
  input  logic        last_key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] random_word_o
);
  import mtwg_pkg::*;

  localparam int unsigned KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned KCW = $clog2(KEY_DEPTH + 1);
  localparam logic [KCW-1:0] KEY_FULL = KCW'(KEY_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SEED_START, S_SEED_MUL, S_SEED_WR,
    S_K_RD, S_K_WR, S_K_FIN, S_D1, S_D2, S_D3, S_D4
  } state_e;

  state_e              state_q;
  logic [31:0]         seed_val_q, p_q, prod_q, a_q, b_q, word_q, out_word_q;
  logic                key_mode_q, phase_q, out_valid_q;
  logic [STATE_AW-1:0] n_q, i_q, kcnt_q, pos_q, rp_q;
  logic [KAW-1:0]      j_q;
  logic [KCW-1:0]      key_count_q, key_len_q;

  logic                st_we;
  logic [STATE_AW-1:0] st_addr;
  logic [31:0]         st_wdata, st_rdata;
  logic                key_we;
  logic [KAW-1:0]      key_addr;
  logic [31:0]         key_rdata;
  logic                accept;
  logic                out_load;
  logic [STATE_AW-1:0] draw_pos, pos_next, pos_far;
  logic [31:0]         key_res, twist_res;

  assign in_ready_o    = (state_q == S_IDLE);
  assign accept        = in_valid_i && in_ready_o;
  assign out_load      = (state_q == S_D4) && (!out_valid_q || out_ready_i);
  assign draw_pos      = (rp_q == WRAP_IDX) ? '0 : rp_q;
  assign pos_next      = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
  assign pos_far       = (pos_q < FAR_SPLIT) ? pos_q + FAR_ADD : pos_q - FAR_SPLIT;
  assign twist_res     = twist_word(a_q, b_q, st_rdata);
  assign key_res       = phase_q ? ((st_rdata ^ prod_q) - 32'(i_q))
                                 : ((st_rdata ^ prod_q) + key_rdata + 32'(j_q));
  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;

  always_comb begin
    st_we    = 1'b0;
    st_addr  = draw_pos;
    st_wdata = prod_q + 32'(n_q);
    unique case (state_q)
      S_IDLE:       st_addr = draw_pos;
      S_SEED_START: begin st_we = 1'b1; st_addr = '0; st_wdata = seed_val_q; end
      S_SEED_MUL:   st_addr = n_q;
      S_SEED_WR:    begin st_we = 1'b1; st_addr = n_q; end
      S_K_RD:       st_addr = i_q;
      S_K_WR:       begin st_we = 1'b1; st_addr = i_q; st_wdata = key_res; end
      S_K_FIN:      begin st_we = 1'b1; st_addr = '0; st_wdata = TOP_BIT; end
      S_D1:         st_addr = pos_next;
      S_D2:         st_addr = pos_far;
      S_D3:         begin st_we = 1'b1; st_addr = pos_q; st_wdata = twist_res; end
      S_D4:         st_addr = pos_q;
      default:      st_addr = draw_pos;
    endcase
  end

  assign key_we   = accept && (kind_i == KIND_KEY) && (key_count_q < KEY_FULL);
  assign key_addr = key_we ? key_count_q[KAW-1:0] : j_q;

  mtwg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS), .AW(STATE_AW)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata)
  );

  mtwg_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH), .AW(KAW)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .addr_i  (key_addr),
    .wdata_i (value_i),
    .rdata_o (key_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SEED_START;
      seed_val_q  <= INIT_SEED;
      key_mode_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      rp_q        <= WRAP_IDX;
      key_count_q <= '0;
      key_len_q   <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      kcnt_q      <= '0;
      pos_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (kind_i)
              KIND_SEED: begin
                seed_val_q <= value_i;
                key_mode_q <= 1'b0;
                state_q    <= S_SEED_START;
              end
              KIND_DRAW: begin
                pos_q   <= draw_pos;
                state_q <= S_D1;
              end
              KIND_KEY: begin
                if (key_count_q < KEY_FULL) begin
                  key_count_q <= key_count_q + 1'b1;
                end
                if (last_key_i) begin
                  key_len_q  <= (key_count_q < KEY_FULL) ? key_count_q + 1'b1 : key_count_q;
                  seed_val_q <= INIT_SEED;
                  key_mode_q <= 1'b1;
                  state_q    <= S_SEED_START;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SEED_START: begin
          p_q     <= seed_val_q;
          n_q     <= STATE_AW'(1);
          state_q <= S_SEED_MUL;
        end
        S_SEED_MUL: begin
          prod_q  <= SEED_MULT * mix_word(p_q);
          state_q <= S_SEED_WR;
        end
        S_SEED_WR: begin
          if (n_q == LAST_IDX) begin
            rp_q <= WRAP_IDX;
            if (key_mode_q) begin
              // first key step mixes word 0, which is the seed itself
              p_q     <= seed_val_q;
              i_q     <= STATE_AW'(1);
              j_q     <= '0;
              phase_q <= 1'b0;
              kcnt_q  <= LAST_IDX;
              state_q <= S_K_RD;
            end else begin
              p_q     <= st_wdata;
              state_q <= S_IDLE;
            end
          end else begin
            p_q     <= st_wdata;
            n_q     <= n_q + 1'b1;
            state_q <= S_SEED_MUL;
          end
        end
        S_K_RD: begin
          prod_q  <= (phase_q ? KEY_MULT2 : KEY_MULT1) * mix_word(p_q);
          state_q <= S_K_WR;
        end
        S_K_WR: begin
          // word 0 is not rewritten on wrap: p_q already carries it forward
          p_q <= key_res;
          i_q <= (i_q == LAST_IDX) ? STATE_AW'(1) : i_q + 1'b1;
          if (!phase_q) begin
            j_q <= (KCW'(j_q) + 1'b1 >= key_len_q) ? '0 : j_q + 1'b1;
          end
          if (kcnt_q == '0) begin
            if (phase_q) begin
              state_q <= S_K_FIN;
            end else begin
              phase_q <= 1'b1;
              kcnt_q  <= LAST_IDX - 1'b1;
              state_q <= S_K_RD;
            end
          end else begin
            kcnt_q  <= kcnt_q - 1'b1;
            state_q <= S_K_RD;
          end
        end
        S_K_FIN: begin
          rp_q        <= WRAP_IDX;
          key_count_q <= '0;
          key_mode_q  <= 1'b0;
          state_q     <= S_IDLE;
        end
        S_D1: begin
          a_q     <= st_rdata;
          state_q <= S_D2;
        end
        S_D2: begin
          b_q     <= st_rdata;
          state_q <= S_D3;
        end
        S_D3: begin
          word_q  <= twist_res;
          rp_q    <= pos_q + 1'b1;
          state_q <= S_D4;
        end
        S_D4: begin
          if (out_load) begin
            out_word_q <= temper_word(word_q);
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= WRAP_IDX)
    else $error("read position beyond state size");

  a_key_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= KEY_FULL)
    else $error("key count beyond buffer depth");

  a_key_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_K_WR) |-> (i_q != '0) && (i_q <= LAST_IDX))
    else $error("key init index out of range");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D4 && out_valid_q && !out_ready_i) |=> (state_q == S_D4)
      && $stable(out_word_q))
    else $error("pending result overwritten");
`endif

endmodule

/* bench/tb.sv */
// Testbench for mt19937_word_generator_core: seed, key and draw requests with
// a local predictor of the generator state. Depends on mtwg_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import mtwg_pkg::*;

  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int NUM_ITEMS = 1200;
  localparam int QUIET_TAIL = 150;
  localparam int STUCK_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int KEY_SLOTS = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;
    logic        typed;
    logic [31:0] word;
  } req_row_t;

  localparam int NUM_ROWS = 19;
  req_row_t dir_rows [NUM_ROWS] = '{
    '{KIND_DRAW, 32'h0,        1'b0, 1'b0, 32'd0},
    '{KIND_NOP,  32'hffffffff, 1'b1, 1'b0, 32'd0},
    '{KIND_DRAW, 32'h0,        1'b0, 1'b0, 32'd0},
    '{KIND_SEED, 32'd5489,     1'b0, 1'b0, 32'd0},
    '{KIND_DRAW, 32'h0,        1'b0, 1'b1, 32'd3499211612},
    '{KIND_DRAW, 32'h0,        1'b0, 1'b0, 32'd0},
    '{KIND_KEY,  32'h123,      1'b0, 1'b0, 32'd0},
    '{KIND_KEY,  32'h234,      1'b0, 1'b0, 32'd0},
    '{KIND_KEY,  32'h345,      1'b0, 1'b0, 32'd0},
    '{KIND_KEY,  32'h456,      1'b1, 1'b0, 32'd0},
    '{KIND_DRAW, 32'h0,        1'b0, 1'b1, 32'd1067595299},
    '{KIND_SEED, 32'h0,        1'b1, 1'b0, 32'd0},
    '{KIND_DRAW, 32'h0,        1'b0, 1'b0, 32'd0},
    '{KIND_SEED, 32'hffffffff, 1'b0, 1'b0, 32'd0},
    '{KIND_DRAW, 32'h0,        1'b0, 1'b0, 32'd0},
    '{KIND_KEY,  32'hffffffff, 1'b1, 1'b0, 32'd0},
    '{KIND_DRAW, 32'hffffffff, 1'b1, 1'b0, 32'd0},
    '{KIND_KEY,  32'h0,        1'b1, 1'b0, 32'd0},
    '{KIND_DRAW, 32'h0,        1'b0, 1'b0, 32'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [31:0] value_i;
  logic        last_key_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] random_word_o;

  mt19937_word_generator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .last_key_i    (last_key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .random_word_o (random_word_o)
  );

  // generator state mirror
  logic [31:0] mt_words [STATE_WORDS];
  int unsigned mt_pos;
  logic [31:0] key_words [KEY_SLOTS];
  int unsigned key_cnt;

  logic [31:0] pending_words [$];
  int errors;
  int stuck_cycles;
  int sent;
  bit quiet;
  bit hold_req;
  bit stim_done;

  function automatic logic [31:0] fold30(logic [31:0] p);
    return p ^ (p >> 30);
  endfunction

  function automatic void reseed(logic [31:0] s);
    mt_words[0] = s;
    for (int n = 1; n < STATE_WORDS; n++)
      mt_words[n] = SEED_MULT * fold30(mt_words[n-1]) + 32'(n);
    mt_pos = STATE_WORDS;
  endfunction

  function automatic void key_schedule(int unsigned len);
    int unsigned i;
    int unsigned j;
    i = 1;
    j = 0;
    if (len == 0) len = 1;
    reseed(INIT_SEED);
    for (int k = (STATE_WORDS > len ? STATE_WORDS : len); k > 0; k--) begin
      mt_words[i] = (mt_words[i] ^ (fold30(mt_words[i-1]) * KEY_MULT1)) + key_words[j] + 32'(j);
      i++;
      j++;
      if (i >= STATE_WORDS) begin
        mt_words[0] = mt_words[STATE_WORDS-1];
        i = 1;
      end
      if (j >= len) j = 0;
    end
    for (int k = STATE_WORDS - 1; k > 0; k--) begin
      mt_words[i] = (mt_words[i] ^ (fold30(mt_words[i-1]) * KEY_MULT2)) - 32'(i);
      i++;
      if (i >= STATE_WORDS) begin
        mt_words[0] = mt_words[STATE_WORDS-1];
        i = 1;
      end
    end
    mt_words[0] = TOP_BIT;
    mt_pos = STATE_WORDS;
  endfunction

  function automatic logic [31:0] next_word();
    logic [31:0] y;
    if (mt_pos >= STATE_WORDS) begin
      for (int n = 0; n < STATE_WORDS; n++) begin
        y = (mt_words[n] & TOP_BIT) | (mt_words[(n+1) % STATE_WORDS] & ~TOP_BIT);
        mt_words[n] = mt_words[(n + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1)
                      ^ (y[0] ? TWIST_XOR : 32'd0);
      end
      mt_pos = 0;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    return y ^ (y >> 18);
  endfunction

  // updates the mirror for a request and queues the expected word of a draw
  function automatic void apply_request(logic [1:0] kind, logic [31:0] value, logic last,
                                        logic typed, logic [31:0] word);
    logic [31:0] w;
    case (kind)
      KIND_SEED: reseed(value);
      KIND_DRAW: begin
        w = next_word();
        pending_words.push_back(typed ? word : w);
      end
      KIND_KEY: begin
        if (key_cnt < KEY_SLOTS) begin
          key_words[key_cnt] = value;
          key_cnt++;
        end
        if (last) begin
          key_schedule(key_cnt);
          key_cnt = 0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send(logic [1:0] kind, logic [31:0] value, logic last,
                      logic typed, logic [31:0] word);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    last_key_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_request(kind, value, last, typed, word);
    sent++;
    if (sent >= NUM_ITEMS + NUM_ROWS - QUIET_TAIL) quiet = 1'b1;
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // stimulus
  initial begin
    int unsigned r;
    int unsigned len;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_DRAW;
    value_i = '0;
    last_key_i = 1'b0;
    errors = 0;
    sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    stim_done = 1'b0;
    key_cnt = 0;
    reseed(INIT_SEED);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int n = 0; n < NUM_ROWS; n++)
      send(dir_rows[n].kind, dir_rows[n].value, dir_rows[n].last,
           dir_rows[n].typed, dir_rows[n].word);

    // a long draw run crosses the twist boundary; the receiver stalls partway
    for (int n = 0; n < 660; n++) begin
      if (n == 100) hold_req = 1'b1;
      send(KIND_DRAW, $urandom, 1'($urandom), 1'b0, '0);
    end

    while (sent < NUM_ITEMS + NUM_ROWS) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send(KIND_SEED, $urandom, 1'($urandom), 1'b0, '0);
      end else if (r < 7) begin
        // key sequence, now and then longer than the buffer
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 8);
        for (int k = 1; k <= len; k++)
          send(KIND_KEY, $urandom, 1'(k == len), 1'b0, '0);
      end else if (r < 10) begin
        send(($urandom_range(0, 5) == 0) ? KIND_KEY : KIND_NOP, $urandom, 1'b0, 1'b0, '0);
      end else begin
        send(KIND_DRAW, $urandom, 1'($urandom), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver readiness
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles = 0;
      else stuck_cycles++;
      if (out_valid_o && out_ready_i) begin
        if (pending_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", random_word_o);
        end else begin
          if (random_word_o !== pending_words[0]) begin
            errors++;
            if (errors <= 10)
              $display("word mismatch: expected %h, got %h", pending_words[0], random_word_o);
          end
          void'(pending_words.pop_front());
        end
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end else begin
      stuck_cycles = 0;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
